### design/tsei_pkg.sv
`timescale 1ns / 1ps

package tsei_pkg;

	// Screen geometry defaults
	localparam int ROWS_DEF = 10;
	localparam int COLS_DEF = 10;

	// Character codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// Command letters that follow a caret
	localparam logic [7:0] CMD_CLEAR = 8'h63; // c
	localparam logic [7:0] CMD_HOME  = 8'h68; // h
	localparam logic [7:0] CMD_BOL   = 8'h62; // b
	localparam logic [7:0] CMD_DOWN  = 8'h64; // d
	localparam logic [7:0] CMD_UP    = 8'h75; // u
	localparam logic [7:0] CMD_LEFT  = 8'h6C; // l
	localparam logic [7:0] CMD_RIGHT = 8'h72; // r
	localparam logic [7:0] CMD_ERASE = 8'h65; // e
	localparam logic [7:0] CMD_INS   = 8'h69; // i
	localparam logic [7:0] CMD_OVR   = 8'h6F; // o

	// Screen update for the current item, plus cursor and mode before the update
	typedef struct packed {
		logic       put;      // write ch at cursor
		logic [7:0] ch;
		logic       clr_all;  // whole screen to spaces
		logic       erase;    // cursor to end of row to spaces
		logic       insert;   // insert mode
		logic [3:0] row;      // cursor row
		logic [3:0] col;      // cursor column
	} tsei_cmd_t;

	// Digit value of an ASCII byte, zero for anything else
	function automatic logic [3:0] digit_or_zero(input logic [7:0] b);
		logic [7:0] d;
		d = b - CH_ZERO;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			return d[3:0];
		end
		return 4'd0;
	endfunction

endpackage

### design/terminal_screen_escape_interpreter_core.sv
`timescale 1ns / 1ps

// Caret-escape text terminal on a ROWS x COLS screen held in flip-flops. Each item is
// either a stream byte (op 0, no result) or a cell read (op 1, one result carrying the
// cell, the cursor and the insert flag). Items are taken into an input register and
// finished from there, one per clock unless a read meets a pending result: parsing, row
// shift, erase and full clear all complete as the item leaves that register; stream bytes
// pass while a result waits. A read sees every byte accepted before it. Reset sets all
// cells to spaces, the cursor home and overwrite mode; there is no clearing pass.
module terminal_screen_escape_interpreter_core #(
	parameter int ROWS = tsei_pkg::ROWS_DEF,
	parameter int COLS = tsei_pkg::COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] data_byte,
	input  logic [3:0] read_row,
	input  logic [3:0] read_col,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_char,
	output logic [3:0] cursor_row,
	output logic [3:0] cursor_col,
	output logic       insert_on
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic [3:0] rrow_s1;
	logic [3:0] rcol_s1;
	logic       adv_s1;
	logic       feed_go;

	logic       out_valid_q;
	logic [7:0] cell_q;
	logic [3:0] crow_q;
	logic [3:0] ccol_q;
	logic       ins_q;

	tsei_pkg::tsei_cmd_t cmd;
	logic [7:0] scr [ROWS][COLS];
	logic [7:0] rd_char;

	// Stage 1 moves on unless a read would overwrite a pending result
	assign adv_s1   = valid_s1 && (!op_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign feed_go  = valid_s1 && !op_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
			rrow_s1 <= read_row;
			rcol_s1 <= read_col;
		end
	end

	tsei_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (feed_go),
		.data_byte (byte_s1),
		.cmd       (cmd)
	);

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		tsei_row #(.COLS(COLS)) u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.sel    (feed_go && (cmd.row == 4'(r))),
			.cmd    (cmd),
			.cells  (scr[r])
		);
	end

	// Cell read, zero outside the screen
	always_comb begin
		rd_char = 8'd0;
		if (rrow_s1 < 4'(ROWS) && rcol_s1 < 4'(COLS)) begin
			rd_char = scr[rrow_s1[RW-1:0]][rcol_s1[CW-1:0]];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && op_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && op_s1) begin
			cell_q <= rd_char;
			crow_q <= cmd.row;
			ccol_q <= cmd.col;
			ins_q  <= cmd.insert;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_char  = cell_q;
	assign cursor_row = crow_q;
	assign cursor_col = ccol_q;
	assign insert_on  = ins_q;

	// Cursor never leaves the screen
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row < 4'(ROWS) && cmd.col < 4'(COLS))
		else $error("cursor outside screen");

	// A result appears only after a read left stage 1
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && op_s1))
		else $error("result without a read item");

	// A waiting result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(adv_s1 && op_s1))
		else $error("pending result overwritten");

	// Clear command blanks the screen (checked on the first cell)
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		feed_go && cmd.clr_all |=> scr[0][0] == tsei_pkg::CH_SPACE)
		else $error("clear did not blank the screen");

endmodule

### design/tsei_ctrl.sv
`timescale 1ns / 1ps

// Escape parser: holds cursor, mode, parse phase and pending row
module tsei_ctrl #(
	parameter int ROWS = tsei_pkg::ROWS_DEF,
	parameter int COLS = tsei_pkg::COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [7:0]           data_byte,
	output tsei_pkg::tsei_cmd_t  cmd
);

	localparam logic [1:0] PH_TEXT  = 2'd0;
	localparam logic [1:0] PH_CARET = 2'd1;
	localparam logic [1:0] PH_ROW   = 2'd2;

	logic [3:0] row_q, row_d;
	logic [3:0] col_q, col_d;
	logic       ins_q, ins_d;
	logic [1:0] ph_q, ph_d;
	logic [3:0] pend_q, pend_d;
	logic       put;
	logic       clr_all;
	logic       erase;
	logic [3:0] pend_row_c;
	logic [3:0] dig_col_c;
	logic [3:0] dig;

	// Clamped placement coordinates
	always_comb begin
		dig = tsei_pkg::digit_or_zero(data_byte);
		pend_row_c = (pend_q >= 4'(ROWS)) ? 4'(ROWS - 1) : pend_q;
		dig_col_c  = (dig >= 4'(COLS)) ? 4'(COLS - 1) : dig;
	end

	// Next state for one stream byte
	always_comb begin
		row_d   = row_q;
		col_d   = col_q;
		ins_d   = ins_q;
		ph_d    = ph_q;
		pend_d  = pend_q;
		put     = 1'b0;
		clr_all = 1'b0;
		erase   = 1'b0;
		if (go) begin
			if (data_byte == tsei_pkg::CH_NEWLINE) begin
				if (ph_q == PH_ROW) begin
					row_d = pend_row_c;
					col_d = '0;
				end
				ph_d = PH_TEXT;
			end else begin
				case (ph_q)
					PH_CARET: begin
						ph_d = PH_TEXT;
						case (data_byte)
							tsei_pkg::CMD_CLEAR: clr_all = 1'b1;
							tsei_pkg::CMD_HOME: begin
								row_d = '0;
								col_d = '0;
							end
							tsei_pkg::CMD_BOL: col_d = '0;
							tsei_pkg::CMD_DOWN: begin
								if ({1'b0, row_q} + 5'd1 < 5'(ROWS)) row_d = row_q + 4'd1;
							end
							tsei_pkg::CMD_UP: begin
								if (row_q != 4'd0) row_d = row_q - 4'd1;
							end
							tsei_pkg::CMD_LEFT: begin
								if (col_q != 4'd0) col_d = col_q - 4'd1;
							end
							tsei_pkg::CMD_RIGHT: begin
								if ({1'b0, col_q} + 5'd1 < 5'(COLS)) col_d = col_q + 4'd1;
							end
							tsei_pkg::CMD_ERASE: erase = 1'b1;
							tsei_pkg::CMD_INS: ins_d = 1'b1;
							tsei_pkg::CMD_OVR: ins_d = 1'b0;
							tsei_pkg::CH_CARET: put = 1'b1;
							default: begin
								pend_d = dig;
								ph_d   = PH_ROW;
							end
						endcase
					end
					PH_ROW: begin
						row_d = pend_row_c;
						col_d = dig_col_c;
						ph_d  = PH_TEXT;
					end
					default: begin
						if (data_byte == tsei_pkg::CH_CARET) begin
							ph_d = PH_CARET;
						end else begin
							put = 1'b1;
						end
					end
				endcase
			end
			// written char advances the cursor, saturating at the last column
			if (put && ({1'b0, col_q} + 5'd1 < 5'(COLS))) begin
				col_d = col_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			ins_q  <= 1'b0;
			ph_q   <= PH_TEXT;
			pend_q <= '0;
		end else begin
			row_q  <= row_d;
			col_q  <= col_d;
			ins_q  <= ins_d;
			ph_q   <= ph_d;
			pend_q <= pend_d;
		end
	end

	assign cmd.put     = put;
	assign cmd.ch      = data_byte;
	assign cmd.clr_all = clr_all;
	assign cmd.erase   = erase;
	assign cmd.insert  = ins_q;
	assign cmd.row     = row_q;
	assign cmd.col     = col_q;

endmodule

### design/tsei_row.sv
`timescale 1ns / 1ps

// One screen row: overwrite, insert-shift, erase to end and clear
module tsei_row #(
	parameter int COLS = tsei_pkg::COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sel,
	input  tsei_pkg::tsei_cmd_t  cmd,
	output logic [7:0]           cells [COLS]
);

	logic [7:0] cells_q [COLS];

	for (genvar k = 0; k < COLS; k++) begin : g_cell
		logic [7:0] nxt;
		logic       at_cur;
		logic       past_cur;

		assign at_cur   = (cmd.col == 4'(k));
		assign past_cur = (4'(k) > cmd.col);

		// Cell update
		always_comb begin
			nxt = cells_q[k];
			if (cmd.clr_all) begin
				nxt = tsei_pkg::CH_SPACE;
			end else if (sel && cmd.erase && (at_cur || past_cur)) begin
				nxt = tsei_pkg::CH_SPACE;
			end else if (sel && cmd.put) begin
				if (at_cur) begin
					nxt = cmd.ch;
				end else if (cmd.insert && past_cur) begin
					nxt = (k > 0) ? cells_q[(k > 0) ? k - 1 : 0] : cells_q[k];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cells_q[k] <= tsei_pkg::CH_SPACE;
			end else begin
				cells_q[k] <= nxt;
			end
		end

		assign cells[k] = cells_q[k];
	end

endmodule

### test/terminal_screen_escape_interpreter_core_tb.sv
`timescale 1ns / 1ps

module terminal_screen_escape_interpreter_core_tb;

	localparam int ROWS = tsei_pkg::ROWS_DEF;
	localparam int COLS = tsei_pkg::COLS_DEF;
	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CALM_TAIL = 200;     // last items go through with no idling
	localparam int HOLD_AT = 300;       // accepted items before the long output hold
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum logic [1:0] {
		PH_TEXT,
		PH_CARET,
		PH_ROW
	} parse_phase_t;

	typedef struct {
		logic       op;
		logic [7:0] data_byte;
		logic [3:0] read_row;
		logic [3:0] read_col;
	} term_item_t;

	typedef struct {
		logic [7:0] glyph;
		logic [3:0] row;
		logic [3:0] col;
		logic       ins;
	} cell_report_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       op = OP_FEED;
	logic [7:0] data_byte = 8'd0;
	logic [3:0] read_row = 4'd0;
	logic [3:0] read_col = 4'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] cell_char;
	logic [3:0] cursor_row;
	logic [3:0] cursor_col;
	logic       insert_on;

	terminal_screen_escape_interpreter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data_byte (data_byte),
		.read_row  (read_row),
		.read_col  (read_col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cell_char (cell_char),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.insert_on (insert_on)
	);

	term_item_t   pending_items[$];
	cell_report_t expected_reports[$];
	int           total_items = 0;
	int           accepted_count = 0;
	int           error_count = 0;
	int           cycle_count = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	int           hold_left = 0;
	bit           hold_done = 1'b0;
	bit           in_accepted = 1'b0;
	bit           sprinkle_reads = 1'b0;

	// Terminal state as the block should hold it
	logic [7:0]   screen_model [ROWS][COLS];
	logic [3:0]   cur_row;
	logic [3:0]   cur_col;
	logic [3:0]   pend_row;
	logic         ins_mode;
	parse_phase_t phase;

	function automatic logic [3:0] digit_value(input logic [7:0] b);
		if (b >= tsei_pkg::CH_ZERO && b <= tsei_pkg::CH_NINE) begin
			return 4'(b - tsei_pkg::CH_ZERO);
		end
		return 4'd0;
	endfunction

	function automatic logic [3:0] clamp_coord(input logic [3:0] v, input int limit);
		return (v >= limit) ? 4'(limit - 1) : v;
	endfunction

	// Write at the cursor, shifting the row right in insert mode
	function automatic void put_glyph(input logic [7:0] ch);
		int k;
		if (ins_mode) begin
			for (k = COLS - 1; k > cur_col; k--) begin
				screen_model[cur_row][k] = screen_model[cur_row][k - 1];
			end
		end
		screen_model[cur_row][cur_col] = ch;
		if (cur_col + 1 < COLS) begin
			cur_col = cur_col + 4'd1;
		end
	endfunction

	// Byte following a caret
	function automatic void run_escape(input logic [7:0] b);
		int r;
		int c;
		case (b)
			tsei_pkg::CMD_CLEAR: begin
				for (r = 0; r < ROWS; r++) begin
					for (c = 0; c < COLS; c++) begin
						screen_model[r][c] = tsei_pkg::CH_SPACE;
					end
				end
			end
			tsei_pkg::CMD_HOME: begin
				cur_row = 4'd0;
				cur_col = 4'd0;
			end
			tsei_pkg::CMD_BOL: cur_col = 4'd0;
			tsei_pkg::CMD_DOWN: begin
				if (cur_row + 1 < ROWS) begin
					cur_row = cur_row + 4'd1;
				end
			end
			tsei_pkg::CMD_UP: begin
				if (cur_row > 0) begin
					cur_row = cur_row - 4'd1;
				end
			end
			tsei_pkg::CMD_LEFT: begin
				if (cur_col > 0) begin
					cur_col = cur_col - 4'd1;
				end
			end
			tsei_pkg::CMD_RIGHT: begin
				if (cur_col + 1 < COLS) begin
					cur_col = cur_col + 4'd1;
				end
			end
			tsei_pkg::CMD_ERASE: begin
				for (c = cur_col; c < COLS; c++) begin
					screen_model[cur_row][c] = tsei_pkg::CH_SPACE;
				end
			end
			tsei_pkg::CMD_INS: ins_mode = 1'b1;
			tsei_pkg::CMD_OVR: ins_mode = 1'b0;
			tsei_pkg::CH_CARET: put_glyph(tsei_pkg::CH_CARET);
			default: begin
				// anything else is the row of a placement
				pend_row = digit_value(b);
				phase = PH_ROW;
				return;
			end
		endcase
		phase = PH_TEXT;
	endfunction

	function automatic void apply_stream_byte(input logic [7:0] b);
		if (b == tsei_pkg::CH_NEWLINE) begin
			if (phase == PH_ROW) begin
				cur_row = clamp_coord(pend_row, ROWS);
				cur_col = 4'd0;
			end
			phase = PH_TEXT;
		end else if (phase == PH_CARET) begin
			run_escape(b);
		end else if (phase == PH_ROW) begin
			cur_row = clamp_coord(pend_row, ROWS);
			cur_col = clamp_coord(digit_value(b), COLS);
			phase = PH_TEXT;
		end else if (b == tsei_pkg::CH_CARET) begin
			phase = PH_CARET;
		end else begin
			put_glyph(b);
		end
	endfunction

	function automatic void push_read(input logic [3:0] r, input logic [3:0] c);
		term_item_t it;
		it.op = OP_READ;
		it.data_byte = 8'($urandom);
		it.read_row = r;
		it.read_col = c;
		pending_items = {pending_items, it};
	endfunction

	function automatic logic [3:0] random_coord();
		if ($urandom_range(0, 7) == 0) begin
			return 4'($urandom_range(10, 15));
		end
		return 4'($urandom_range(0, 9));
	endfunction

	// Feed one byte; in the random part a read sometimes slips in first
	function automatic void push_feed(input logic [7:0] b);
		term_item_t it;
		if (sprinkle_reads && $urandom_range(0, 5) == 0) begin
			push_read(random_coord(), random_coord());
		end
		it.op = OP_FEED;
		it.data_byte = b;
		it.read_row = 4'($urandom);
		it.read_col = 4'($urandom);
		pending_items = {pending_items, it};
	endfunction

	function automatic logic [7:0] random_plain();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 3) != 0) begin
				b = 8'($urandom_range(33, 126));
			end else begin
				b = 8'($urandom);
			end
		end while (b == tsei_pkg::CH_CARET || b == tsei_pkg::CH_NEWLINE);
		return b;
	endfunction

	function automatic void push_random_sequence();
		int sel;
		int n;
		sel = $urandom_range(0, 19);
		if (sel <= 6) begin
			n = $urandom_range(1, 6);
			repeat (n) push_feed(random_plain());
		end else if (sel <= 9) begin
			push_feed(tsei_pkg::CH_CARET);
			case ($urandom_range(0, 10))
				0: push_feed(($urandom_range(0, 3) == 0) ? tsei_pkg::CMD_CLEAR
					: tsei_pkg::CMD_HOME);
				1: push_feed(tsei_pkg::CMD_BOL);
				2: push_feed(tsei_pkg::CMD_DOWN);
				3: push_feed(tsei_pkg::CMD_UP);
				4: push_feed(tsei_pkg::CMD_LEFT);
				5: push_feed(tsei_pkg::CMD_RIGHT);
				6: push_feed(tsei_pkg::CMD_ERASE);
				7: push_feed(tsei_pkg::CMD_INS);
				8: push_feed(tsei_pkg::CMD_OVR);
				9: push_feed(tsei_pkg::CMD_DOWN);
				default: push_feed(tsei_pkg::CMD_UP);
			endcase
		end else if (sel <= 11) begin
			// placement, mostly digits, sometimes junk coordinates
			push_feed(tsei_pkg::CH_CARET);
			push_feed(($urandom_range(0, 5) == 0) ? random_plain()
				: 8'(tsei_pkg::CH_ZERO + $urandom_range(0, 9)));
			push_feed(($urandom_range(0, 5) == 0) ? random_plain()
				: 8'(tsei_pkg::CH_ZERO + $urandom_range(0, 9)));
		end else if (sel == 12) begin
			push_feed(tsei_pkg::CH_CARET);
			push_feed(tsei_pkg::CH_CARET);
		end else if (sel == 13) begin
			push_feed(tsei_pkg::CH_NEWLINE);
		end else if (sel == 14) begin
			// sequence cut short by a line break
			push_feed(tsei_pkg::CH_CARET);
			if ($urandom_range(0, 1) == 0) begin
				push_feed(8'(tsei_pkg::CH_ZERO + $urandom_range(0, 9)));
			end
			push_feed(tsei_pkg::CH_NEWLINE);
		end else begin
			push_read(random_coord(), random_coord());
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus, reset and end of run
	initial begin
		int r;
		int c;
		for (r = 0; r < ROWS; r++) begin
			for (c = 0; c < COLS; c++) begin
				screen_model[r][c] = tsei_pkg::CH_SPACE;
			end
		end
		cur_row = 4'd0;
		cur_col = 4'd0;
		pend_row = 4'd0;
		ins_mode = 1'b0;
		phase = PH_TEXT;

		// directed: field extremes, insert shift, literal caret, saturation,
		// non-digit row ended by a line break, out-of-range read
		push_read(4'hF, 4'hF);
		push_feed(8'hFF);
		push_feed(8'h00);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(tsei_pkg::CMD_INS);
		push_feed(8'h5A);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(tsei_pkg::CMD_HOME);
		push_feed(8'h51);
		push_read(4'd0, 4'd0);
		push_read(4'd0, 4'd3);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(tsei_pkg::CH_NINE);
		push_feed(tsei_pkg::CH_NINE);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(tsei_pkg::CMD_DOWN);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(tsei_pkg::CMD_RIGHT);
		push_feed(8'h77);
		push_read(4'd9, 4'd9);
		push_feed(tsei_pkg::CH_CARET);
		push_feed(8'h78);
		push_feed(tsei_pkg::CH_NEWLINE);
		push_read(4'd9, 4'd8);

		sprinkle_reads = 1'b1;
		n_directed_done: begin
			int base;
			base = pending_items.size();
			while (pending_items.size() < base + RANDOM_ITEMS) begin
				push_random_sequence();
			end
		end
		total_items = pending_items.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_count < total_items || expected_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_reports.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Sender: one item at a time from the queue, random idle bursts
	always @(negedge clk) begin
		term_item_t it;
		if (arst_n && (!in_valid || in_accepted)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (hold_left == 0 && pending_items.size() > CALM_TAIL
				&& $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else begin
				it = pending_items.pop_front();
				op <= it.op;
				data_byte <= it.data_byte;
				read_row <= it.read_row;
				read_col <= it.read_col;
				in_valid <= 1'b1;
			end
		end
	end

	// Receiver: one long hold to back the block up, then random stall bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && accepted_count >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (pending_items.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Predict on accepted items, check accepted results
	always @(posedge clk) begin
		cell_report_t want;
		in_accepted = arst_n && in_valid && in_ready;
		if (in_accepted) begin
			accepted_count++;
			if (op == OP_READ) begin
				want.glyph = (read_row < ROWS && read_col < COLS)
					? screen_model[read_row][read_col] : 8'd0;
				want.row = cur_row;
				want.col = cur_col;
				want.ins = ins_mode;
				expected_reports = {expected_reports, want};
			end else begin
				apply_stream_byte(data_byte);
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				error_count++;
				$display({"%0t: unexpected result, expected none, ",
					"actual cell %0d row %0d col %0d ins %0d"},
					$time, cell_char, cursor_row, cursor_col, insert_on);
			end else begin
				want = expected_reports.pop_front();
				check_field("cell_char", want.glyph, cell_char);
				check_field("cursor_row", want.row, cursor_row);
				check_field("cursor_col", want.col, cursor_col);
				check_field("insert_on", want.ins, insert_on);
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("status: fail");
			$finish;
		end
	end

endmodule
